FILE: rtl/assert_macros.svh
// Assertion macros used by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sfd_pkg.sv
// Constants and CRC helper for the sync-word deframer.
`default_nettype none

package sfd_pkg;

  localparam int FRAME_BYTES   = 32;
  localparam int CHECKED_BYTES = 26;
  localparam int SYNC_LEN      = 2;
  localparam int CKS_OFS       = SYNC_LEN + CHECKED_BYTES;

  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam int FILL_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W  = 5;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;

  typedef logic [7:0] byte_t;

  // One byte of reflected CRC-32, eight bit steps.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in, input byte_t data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sync_frame_deframer_crc32_unit.sv
// Sync-word deframer with reflected CRC-32 check over a sliding byte window.
// Use:
//   in_*  : one received byte per transfer (in_tdata[7:0] = rx_byte).
//   out_* : checked frame bytes, in order; out_tdata[7:0] = frame_byte,
//           out_tdata[12:8] = byte_index, out_tlast marks the final byte.
//   cfg_* : register writes; index 0 = sync_first, 1 = sync_second, other
//           indices are ignored. Always ready; write only while idle.
// Timing:
//   While the window is filling, a byte is written to the window RAM and produces nothing.
//   A byte that completes the window starts a scan: the 32 window bytes are
//   read from the window RAM one a cycle; the two sync bytes are compared,
//   the 26 checked bytes go through a single byte-wide CRC unit and the last
//   four form the checksum. A flush state drains the read pipe, then a check
//   state compares. On a match the 26 checked bytes are read back and
//   presented in order, each by a read state, then a load of the output
//   register, which waits while the receiver does not take the output.
//   A stalled receiver holds the block in emission; in_tready stays low.
//   The final frame byte may still wait on out_* while the next byte is taken.
// Reset: window empty, sync registers 0xAA/0x55, no output pending.
// The window RAM needs no clearing; only written entries are read.
`default_nettype none

module sync_frame_deframer_crc32_unit (
  input  wire         clk,
  input  wire         rst_n,
  // slave side: [7:0] rx_byte
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,
  // master side: [7:0] frame_byte, [12:8] byte_index, [15:13] zero
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  // configuration write channel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);
  import sfd_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_FLUSH   = 3'd2;
  localparam logic [2:0] S_CHECK   = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_LD = 3'd5;

  // window RAM, circular, oldest byte at head_r
  byte_t mem [FRAME_BYTES];

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [ADDR_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0]  emit_r, emit_nxt;
  logic              dv_r;
  logic [ADDR_W-1:0] didx_r;
  byte_t             rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       crc_r, crc_nxt;
  logic [31:0]       cks_r, cks_nxt;
  logic              sync_ok_r, sync_ok_nxt;
  byte_t             sync_first_r, sync_second_r;
  logic              out_valid_r, out_valid_nxt;
  byte_t             out_byte_r, out_byte_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_last_r, out_last_nxt;
  logic              in_fire, out_fire, out_free, emit_last;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_valid_r && out_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign emit_last  = (emit_r == IDX_W'(CHECKED_BYTES - 1));
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_idx_r, out_byte_r};
  assign out_tlast  = out_last_r;

  assign wr_addr = head_r + fill_r[ADDR_W-1:0];

  always_comb begin
    case (state_r)
      S_EMIT_RD, S_EMIT_LD: rd_addr = head_r + ADDR_W'(SYNC_LEN) + ADDR_W'(emit_r);
      default:              rd_addr = head_r + scan_r;
    endcase
  end

  // RAM: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[wr_addr] <= in_tdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // byte consumer: sync compare, CRC unit, checksum shift-in
  always_comb begin
    crc_nxt     = crc_r;
    cks_nxt     = cks_r;
    sync_ok_nxt = sync_ok_r;
    if (in_fire) begin
      crc_nxt     = CRC_INIT;
      sync_ok_nxt = 1'b1;
    end else if (dv_r) begin
      if (didx_r == ADDR_W'(0)) begin
        sync_ok_nxt = sync_ok_r && (rd_data_r == sync_first_r);
      end else if (didx_r == ADDR_W'(1)) begin
        sync_ok_nxt = sync_ok_r && (rd_data_r == sync_second_r);
      end else if (didx_r < ADDR_W'(CKS_OFS)) begin
        crc_nxt = crc32_byte(crc_r, rd_data_r);
      end else begin
        cks_nxt = {rd_data_r, cks_r[31:8]};  // little-endian
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    scan_nxt      = scan_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          fill_nxt = fill_r + FILL_W'(1);
          if (fill_r == FILL_W'(FRAME_BYTES - 1)) begin
            state_nxt = S_SCAN;
            scan_nxt  = '0;
          end
        end
      end
      S_SCAN: begin
        scan_nxt = scan_r + ADDR_W'(1);
        if (scan_r == ADDR_W'(FRAME_BYTES - 1)) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: state_nxt = S_CHECK;
      S_CHECK: begin
        if (sync_ok_r && (~crc_r == cks_r)) begin
          fill_nxt  = '0;
          emit_nxt  = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          head_nxt  = head_r + ADDR_W'(1);
          fill_nxt  = FILL_W'(FRAME_BYTES - 1);
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_RD: state_nxt = S_EMIT_LD;
      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data_r;
          out_idx_nxt   = emit_r;
          out_last_nxt  = emit_last;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            emit_nxt  = emit_r + IDX_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= '0;
      fill_r        <= '0;
      dv_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      sync_first_r  <= 8'hAA;
      sync_second_r <= 8'h55;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      dv_r        <= (state_r == S_SCAN);
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SYNC_FIRST) begin
          sync_first_r <= cfg_data;
        end else if (cfg_index == REG_SYNC_SECOND) begin
          sync_second_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    emit_r     <= emit_nxt;
    didx_r     <= scan_r;
    crc_r      <= crc_nxt;
    cks_r      <= cks_nxt;
    sync_ok_r  <= sync_ok_nxt;
    out_byte_r <= out_byte_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

`include "assert_macros.svh"

  `SFD_ASSERT(a_fill_range, fill_r <= FILL_W'(FRAME_BYTES), "window fill count overflow")
  `SFD_ASSERT(a_short_stays_idle,
              in_fire && (fill_r < FILL_W'(FRAME_BYTES - 1)) |=> state_r == S_IDLE,
              "scan started before window full")
  `SFD_ASSERT(a_check_exit,
              state_r == S_CHECK |=> (state_r == S_EMIT_RD) || (state_r == S_IDLE),
              "bad exit from check")
  `SFD_ASSERT(a_last_index,
              out_valid_r && out_last_r |-> out_idx_r == IDX_W'(CHECKED_BYTES - 1),
              "tlast on wrong byte")
  `SFD_ASSERT_ALWAYS(a_reset_clear,
                     !rst_n |=> !out_valid_r && (fill_r == '0),
                     "reset left state behind")

endmodule

`default_nettype wire
